### rtl/core/pjrm_pkg.sv
// pjrm_pkg: shared types and constants of the periodic job release manager
// used by pjrm_cell, periodic_job_release_manager_core and pjrm_checker
`default_nettype none

package pjrm_pkg;

  localparam int TASK_SLOTS = 8;
  localparam int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int SLOT_W     = 3;
  localparam int TIME_W     = 32;
  localparam int ACT_W      = 3;
  localparam int CMP_W      = 8;
  localparam int S_TDATA_W  = 104;
  localparam int M_TDATA_W  = 72;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_START = 2'd2,
    REQ_END   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    POL_NONE  = 2'd0,
    POL_SKIP  = 2'd1,
    POL_KILL  = 2'd2,
    POL_CATCH = 2'd3
  } pol_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE     = 3'd0,
    ACT_RELEASED = 3'd1,
    ACT_SKIPPED  = 3'd2,
    ACT_KILLED   = 3'd3,
    ACT_CAUGHT   = 3'd4,
    ACT_ERROR    = 3'd5,
    ACT_ACK      = 3'd6
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_TICK
  } state_e;

  typedef struct packed {
    req_e              req_type;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] deadline;
    pol_e              policy;
  } cmd_t;

  // step moves the tick token one cell on, cmd_en applies a load/start/end
  typedef struct packed {
    logic step;
    logic cmd_en;
  } ctl_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    act_e              action;
    logic [TIME_W-1:0] job;
    logic [TIME_W-1:0] abs_dl;
    logic              miss;
  } res_t;

endpackage

`default_nettype wire

### rtl/core/pjrm_cell.sv
// pjrm_cell: one task slot of the release chain with its own release logic
// depends on pjrm_pkg; passes the tick token and tick time to the next cell
`default_nettype none

module pjrm_cell (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [pjrm_pkg::IDX_W-1:0]       cell_idx_i,
  input  wire pjrm_pkg::ctl_t                   ctl_i,
  input  wire pjrm_pkg::cmd_t                   cmd_i,
  input  wire logic                             tok_i,
  input  wire logic [pjrm_pkg::TIME_W-1:0]      now_i,
  output logic                                  tok_o,
  output logic [pjrm_pkg::TIME_W-1:0]           now_o,
  output pjrm_pkg::res_t                        res_o
);

  logic                          valid_q, valid_d;
  logic                          run_q, run_d;
  logic [pjrm_pkg::TIME_W-1:0]   per_q, per_d;
  logic [pjrm_pkg::TIME_W-1:0]   pd_q, pd_d;
  pjrm_pkg::pol_e                pol_q, pol_d;
  logic [pjrm_pkg::TIME_W-1:0]   lrt_q, lrt_d;
  logic [pjrm_pkg::TIME_W-1:0]   abs_q, abs_d;
  logic [pjrm_pkg::TIME_W-1:0]   job_q, job_d;
  logic                          tok_q;
  logic [pjrm_pkg::TIME_W-1:0]   now_q;

  logic                          match;
  logic                          upd;
  logic                          due;
  logic [pjrm_pkg::TIME_W-1:0]   elapsed;
  logic [pjrm_pkg::TIME_W-1:0]   rel_lrt;
  logic [pjrm_pkg::TIME_W-1:0]   rel_abs;
  logic [pjrm_pkg::TIME_W-1:0]   dl_eff;

  assign match   = (pjrm_pkg::CMP_W'(cell_idx_i) == pjrm_pkg::CMP_W'(cmd_i.slot));
  assign upd     = (tok_i && ctl_i.step) || (ctl_i.cmd_en && match);
  assign elapsed = now_i - lrt_q;
  assign due     = (elapsed >= per_q);
  assign rel_lrt = lrt_q + per_q;
  // period plus deadline is kept, so the new absolute deadline is one add
  assign rel_abs = lrt_q + pd_q;
  assign dl_eff  = (cmd_i.deadline == '0) ? cmd_i.period : cmd_i.deadline;

  always_comb begin
    valid_d = valid_q;
    run_d   = run_q;
    per_d   = per_q;
    pd_d    = pd_q;
    pol_d   = pol_q;
    lrt_d   = lrt_q;
    abs_d   = abs_q;
    job_d   = job_q;
    res_o   = '0;
    if (tok_i) begin
      res_o.slot = pjrm_pkg::SLOT_W'(cell_idx_i);
      if (valid_q) begin
        if (due) begin
          if (!run_q) begin
            job_d        = job_q + 1'b1;
            lrt_d        = rel_lrt;
            abs_d        = rel_abs;
            res_o.action = pjrm_pkg::ACT_RELEASED;
          end else begin
            unique case (pol_q)
              pjrm_pkg::POL_SKIP: begin
                lrt_d        = rel_lrt;
                res_o.action = pjrm_pkg::ACT_SKIPPED;
              end
              pjrm_pkg::POL_KILL: begin
                run_d        = 1'b0;
                job_d        = job_q + 1'b1;
                lrt_d        = rel_lrt;
                abs_d        = rel_abs;
                res_o.action = pjrm_pkg::ACT_KILLED;
              end
              pjrm_pkg::POL_CATCH: begin
                job_d        = job_q + 1'b1;
                lrt_d        = rel_lrt;
                abs_d        = rel_abs;
                res_o.action = pjrm_pkg::ACT_CAUGHT;
              end
              default: begin
                res_o.action = pjrm_pkg::ACT_ERROR;
              end
            endcase
          end
        end
        res_o.job    = job_d;
        res_o.abs_dl = abs_d;
      end
    end else if (ctl_i.cmd_en && match) begin
      unique case (cmd_i.req_type)
        pjrm_pkg::REQ_LOAD: begin
          valid_d      = 1'b1;
          run_d        = 1'b0;
          per_d        = cmd_i.period;
          pd_d         = cmd_i.period + dl_eff;
          pol_d        = cmd_i.policy;
          lrt_d        = cmd_i.now - cmd_i.period;
          abs_d        = '0;
          job_d        = '0;
          res_o.action = pjrm_pkg::ACT_ACK;
        end
        pjrm_pkg::REQ_START: begin
          if (valid_q) begin
            run_d        = 1'b1;
            res_o.action = pjrm_pkg::ACT_ACK;
            res_o.job    = job_q;
            res_o.abs_dl = abs_q;
          end
        end
        pjrm_pkg::REQ_END: begin
          if (valid_q) begin
            run_d        = 1'b0;
            res_o.action = pjrm_pkg::ACT_ACK;
            res_o.job    = job_q;
            res_o.abs_dl = abs_q;
            res_o.miss   = (cmd_i.now > abs_q);
          end
        end
        default: begin
          res_o.action = pjrm_pkg::ACT_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      run_q   <= 1'b0;
      tok_q   <= 1'b0;
    end else begin
      if (upd) begin
        valid_q <= valid_d;
        run_q   <= run_d;
      end
      if (ctl_i.step) begin
        tok_q <= tok_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      per_q <= per_d;
      pd_q  <= pd_d;
      pol_q <= pol_d;
      lrt_q <= lrt_d;
      abs_q <= abs_d;
      job_q <= job_d;
    end
    if (ctl_i.step) begin
      now_q <= now_i;
    end
  end

  assign tok_o = tok_q;
  assign now_o = now_q;

endmodule

`default_nettype wire

### rtl/core/periodic_job_release_manager_core.sv
// periodic_job_release_manager_core: top level, request control and result register
// depends on pjrm_pkg and a chain of pjrm_cell slots
`default_nettype none

// One request is worked at a time. A tick request sends a token down the chain
// of slot cells, one cell per cycle while the result register is free, and each
// cell emits its result as the token passes it; s_axis_tready returns after the
// token has left the last cell, later while the result register is held by
// m_axis_tready. Load, start and end requests go straight to the addressed cell.
// The result register decouples the output side, so a new request is taken
// while the last result still waits.
module periodic_job_release_manager_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // slot[2:0], now[34:3], period[66:35], deadline[98:67], policy[100:99]
  input  wire logic [pjrm_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // req_type[1:0]
  input  wire logic [1:0]                         s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // out_slot[2:0], action[5:3], job_number[37:6], abs_deadline_out[69:38],
  // deadline_missed[70], zero[71]
  output logic [pjrm_pkg::M_TDATA_W-1:0]          m_axis_tdata,
  output logic                                    m_axis_tlast
);

  localparam int N = pjrm_pkg::TASK_SLOTS;

  pjrm_pkg::state_e              state_q, state_d;
  pjrm_pkg::cmd_t                cmd_q;
  logic                          start_q;
  logic                          accept;
  logic                          out_free;
  logic                          emit_tick;
  logic                          wr;
  pjrm_pkg::ctl_t                ctl;
  logic [N:0]                    tok;
  logic [pjrm_pkg::TIME_W-1:0]   now_c [N+1];
  pjrm_pkg::res_t                res [N];
  pjrm_pkg::res_t                res_all;

  logic                          out_valid_q;
  logic [pjrm_pkg::SLOT_W-1:0]   out_slot_q;
  pjrm_pkg::act_e                out_act_q;
  logic [pjrm_pkg::TIME_W-1:0]   out_job_q;
  logic [pjrm_pkg::TIME_W-1:0]   out_abs_q;
  logic                          out_miss_q;
  logic                          out_last_q;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign tok[0]   = start_q;
  assign now_c[0] = cmd_q.now;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pjrm_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (pjrm_pkg::req_e'(s_axis_tuser) == pjrm_pkg::REQ_TICK)
                    ? pjrm_pkg::ST_TICK : pjrm_pkg::ST_CMD;
        end
      end
      pjrm_pkg::ST_CMD: begin
        if (out_free) begin
          state_d = pjrm_pkg::ST_IDLE;
        end
      end
      pjrm_pkg::ST_TICK: begin
        // token has left the last cell
        if (tok[N]) begin
          state_d = pjrm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pjrm_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs of the control
  always_comb begin
    s_axis_tready = 1'b0;
    ctl           = '0;
    emit_tick     = 1'b0;
    unique case (state_q)
      pjrm_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      pjrm_pkg::ST_CMD: begin
        ctl.cmd_en = out_free;
      end
      pjrm_pkg::ST_TICK: begin
        ctl.step  = out_free || tok[N];
        emit_tick = out_free && !tok[N];
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  assign wr = emit_tick || ctl.cmd_en;

  for (genvar i = 0; i < N; i++) begin : g_cell
    pjrm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (pjrm_pkg::IDX_W'(i)),
      .ctl_i      (ctl),
      .cmd_i      (cmd_q),
      .tok_i      (tok[i]),
      .now_i      (now_c[i]),
      .tok_o      (tok[i+1]),
      .now_o      (now_c[i+1]),
      .res_o      (res[i])
    );
  end

  // only the active cell drives a nonzero result
  always_comb begin
    res_all = '0;
    for (int i = 0; i < N; i++) begin
      res_all = pjrm_pkg::res_t'(res_all | res[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pjrm_pkg::ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        start_q <= (pjrm_pkg::req_e'(s_axis_tuser) == pjrm_pkg::REQ_TICK);
      end else if (ctl.step) begin
        start_q <= 1'b0;
      end
      if (wr) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.req_type <= pjrm_pkg::req_e'(s_axis_tuser);
      cmd_q.slot     <= s_axis_tdata[2:0];
      cmd_q.now      <= s_axis_tdata[34:3];
      cmd_q.period   <= s_axis_tdata[66:35];
      cmd_q.deadline <= s_axis_tdata[98:67];
      cmd_q.policy   <= pjrm_pkg::pol_e'(s_axis_tdata[100:99]);
    end
    if (wr) begin
      // the slot field is 3 bits wide, so every slot value matches one of the eight cells
      out_slot_q <= ctl.cmd_en ? cmd_q.slot : res_all.slot;
      out_act_q  <= res_all.action;
      out_job_q  <= res_all.job;
      out_abs_q  <= res_all.abs_dl;
      out_miss_q <= res_all.miss;
      out_last_q <= ctl.cmd_en || tok[N-1];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {1'b0, out_miss_q, out_abs_q, out_job_q, out_act_q, out_slot_q};

endmodule

`default_nettype wire

### rtl/core/pjrm_checker.sv
// pjrm_checker: port level checks of the periodic job release manager
// depends on pjrm_pkg; bound to periodic_job_release_manager_core below
`default_nettype none

module pjrm_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [pjrm_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input wire logic                            m_axis_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // one request at a time: no request right after an accepted one
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while another is in work");

  a_act_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[5:3] <= 3'(pjrm_pkg::ACT_ACK))
    else $error("undefined action code");

  // a deadline miss only comes with the acknowledge of a job end
  a_miss_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[70] |->
      m_axis_tdata[5:3] == 3'(pjrm_pkg::ACT_ACK) && m_axis_tlast)
    else $error("deadline miss outside a job end acknowledge");

endmodule

bind periodic_job_release_manager_core pjrm_checker u_pjrm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
